// ===== sv/lcpd_pkg.sv =====
// Shared types and constants for the length/checksum packet deframer.
package lcpd_pkg;

    // Reset value of the sync marker register
    localparam logic [7:0] SYNC_RESET = 8'h42;

    // Deframer phases
    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_LEN   = 2'd1,
        PH_DATA  = 2'd2,
        PH_CHECK = 2'd3
    } t_phase;

    // Result kinds carried on tuser
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_MISMATCH = 2'd2
    } t_kind;

    // One result item
    typedef struct packed {
        t_kind      kind;
        logic [7:0] expected_check;
        logic [7:0] packet_length;
        logic [7:0] position;
        logic [7:0] data_byte;
    } t_result;

endpackage

// ===== sv/lcpd_core.sv =====
// Deframer state machine and checksum datapath, one byte per cycle while i_valid is high.
module lcpd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,       // byte presented and taken this cycle
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_sync_byte,
    output logic             o_res_valid,
    output lcpd_pkg::t_result o_res
);

    lcpd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_idx, n_idx;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       data_sum;
    logic [7:0]       idx_inc;

    assign data_sum = r_sum + i_byte + r_idx;
    assign idx_inc  = r_idx + 8'd1;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_valid) begin
            unique case (r_phase)
                lcpd_pkg::PH_HUNT: begin
                    if (i_byte == i_sync_byte) n_phase = lcpd_pkg::PH_LEN;
                end
                lcpd_pkg::PH_LEN: begin
                    // zero length skips straight to the check byte
                    n_phase = (i_byte == 8'd0) ? lcpd_pkg::PH_CHECK : lcpd_pkg::PH_DATA;
                end
                lcpd_pkg::PH_DATA: begin
                    if (idx_inc >= r_len) n_phase = lcpd_pkg::PH_CHECK;
                end
                lcpd_pkg::PH_CHECK: begin
                    n_phase = lcpd_pkg::PH_HUNT;
                end
                default: n_phase = lcpd_pkg::PH_HUNT;
            endcase
        end
    end

    // Datapath updates and result item
    always_comb begin
        n_len       = r_len;
        n_idx       = r_idx;
        n_sum       = r_sum;
        o_res_valid = 1'b0;
        o_res.kind           = lcpd_pkg::KIND_PAYLOAD;
        o_res.data_byte      = i_byte;
        o_res.position       = r_idx;
        o_res.packet_length  = r_len;
        o_res.expected_check = ~data_sum;
        unique case (r_phase)
            lcpd_pkg::PH_HUNT: begin
            end
            lcpd_pkg::PH_LEN: begin
                if (i_valid) begin
                    n_len = i_byte;
                    n_idx = 8'd0;
                    n_sum = i_byte;
                end
            end
            lcpd_pkg::PH_DATA: begin
                o_res_valid = i_valid;
                if (i_valid) begin
                    n_sum = data_sum;
                    n_idx = idx_inc;
                end
            end
            lcpd_pkg::PH_CHECK: begin
                o_res_valid          = i_valid;
                o_res.kind           = ((~i_byte) == r_sum) ? lcpd_pkg::KIND_GOOD
                                                            : lcpd_pkg::KIND_MISMATCH;
                o_res.position       = 8'd0;
                o_res.expected_check = ~r_sum;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lcpd_pkg::PH_HUNT;
            r_len   <= 8'd0;
            r_idx   <= 8'd0;
            r_sum   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
        end
    end

endmodule

// ===== sv/lcpd_out_reg.sv =====
// Result register with stream handshake towards the consumer.
module lcpd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,       // slot may take a new item
    input  logic              i_valid,      // item present when loading
    input  lcpd_pkg::t_result i_res,
    output logic              o_ready,      // register free or emptying now
    input  logic              i_m_ready,
    output logic              o_m_valid,
    output lcpd_pkg::t_result o_res
);

    logic              r_valid;
    lcpd_pkg::t_result r_res;

    assign o_ready   = !r_valid || i_m_ready;
    assign o_m_valid = r_valid;
    assign o_res     = r_res;

    // Control: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== sv/length_checksum_packet_deframer_top.sv =====
// Top level of the length/checksum packet deframer.
// Received bytes enter on the s_axis side, one per item. The block hunts for the sync
// byte (register, reset 0x42), takes a length byte, that many payload bytes and a check
// byte. Each payload byte leaves as one item with its index and the running expected
// check; the check byte leaves as a good-end or mismatch item. A sync byte, a length
// byte and bytes dropped while hunting give no item. Sustained rate is one byte per
// clock while m_axis_tready stays high; a result passes the input register, then the
// result register, with the checksum add between them.
// s_axis_tready follows m_axis_tready combinationally when both registers are full.
// The sync register should only be written while no packet is in flight.
module length_checksum_packet_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,     // sync_byte
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,      // [7:0] rx_byte
    // result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,      // [7:0] data_byte, [15:8] position,
                                           // [23:16] packet_length, [31:24] expected_check
    output logic [1:0]  m_axis_tuser       // [1:0] kind
);

    logic [7:0]        r_sync;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              out_ready;
    logic              advance;
    logic              res_valid;
    lcpd_pkg::t_result res;
    lcpd_pkg::t_result out_res;

    // Sync marker register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= lcpd_pkg::SYNC_RESET;
        end else if (i_cfg_wr_en) begin
            r_sync <= i_cfg_wr_data;
        end
    end

    // Input register
    assign advance       = r_in_valid && out_ready;
    assign s_axis_tready = !r_in_valid || out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    lcpd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (advance),
        .i_byte      (r_in_byte),
        .i_sync_byte (r_sync),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lcpd_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (out_ready),
        .i_valid   (advance && res_valid),
        .i_res     (res),
        .o_ready   (out_ready),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_res     (out_res)
    );

    assign m_axis_tdata = {out_res.expected_check, out_res.packet_length,
                           out_res.position, out_res.data_byte};
    assign m_axis_tuser = out_res.kind;

`ifndef ASSERT_OFF
    // payload items always lie inside the packet length
    a_pos_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == lcpd_pkg::KIND_PAYLOAD)
            |-> (m_axis_tdata[15:8] < m_axis_tdata[23:16]))
        else $error("payload position beyond packet length");

    // end items carry position zero and a defined kind
    a_end_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != lcpd_pkg::KIND_PAYLOAD)
            |-> (m_axis_tdata[15:8] == 8'd0 &&
                 (m_axis_tuser == lcpd_pkg::KIND_GOOD ||
                  m_axis_tuser == lcpd_pkg::KIND_MISMATCH)))
        else $error("malformed end item");

    // a held input byte is not lost while the output side is blocked
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_ready) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input byte dropped under back-pressure");
`endif

endmodule

// ===== tb/length_checksum_packet_deframer_checker.sv =====
// Result checker for the packet deframer: tracks accepted bytes, predicts results, compares.
`timescale 1ns / 100ps
module length_checksum_packet_deframer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_hunting
);

    // Own copy of the deframer state
    logic [7:0]       sync_marker;
    lcpd_pkg::t_phase phase;
    logic [7:0]       frame_length;
    logic [7:0]       byte_index;
    logic [7:0]       check_sum;

    // Results still owed by the block, oldest first
    lcpd_pkg::t_result results_due[$];

    // Advance the deframer by one received byte; queue any result it gives
    task automatic deframe_byte(input logic [7:0] rx);
        lcpd_pkg::t_result res;
        case (phase)
            lcpd_pkg::PH_HUNT: begin
                if (rx == sync_marker) phase = lcpd_pkg::PH_LEN;
            end
            lcpd_pkg::PH_LEN: begin
                frame_length = rx;
                byte_index   = 8'd0;
                check_sum    = rx;
                phase        = (rx == 8'd0) ? lcpd_pkg::PH_CHECK : lcpd_pkg::PH_DATA;
            end
            lcpd_pkg::PH_DATA: begin
                check_sum          = check_sum + rx + byte_index;
                res.kind           = lcpd_pkg::KIND_PAYLOAD;
                res.data_byte      = rx;
                res.position       = byte_index;
                res.packet_length  = frame_length;
                res.expected_check = ~check_sum;
                results_due.push_back(res);
                byte_index = byte_index + 8'd1;
                if (byte_index >= frame_length) phase = lcpd_pkg::PH_CHECK;
            end
            default: begin
                res.kind           = (~rx == check_sum) ? lcpd_pkg::KIND_GOOD
                                                        : lcpd_pkg::KIND_MISMATCH;
                res.data_byte      = rx;
                res.position       = 8'd0;
                res.packet_length  = frame_length;
                res.expected_check = ~check_sum;
                results_due.push_back(res);
                phase = lcpd_pkg::PH_HUNT;
            end
        endcase
    endtask

    // Compare one delivered result against the oldest one owed
    task automatic check_result(input lcpd_pkg::t_result got);
        lcpd_pkg::t_result want;
        if (results_due.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: unexpected result kind %0d data %h pos %h len %h chk %h",
                         $realtime, got.kind, got.data_byte, got.position,
                         got.packet_length, got.expected_check);
        end else begin
            want = results_due.pop_front();
            if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                    got.position !== want.position ||
                    got.packet_length !== want.packet_length ||
                    got.expected_check !== want.expected_check) begin
                o_fail_count++;
                if (o_fail_count <= 10)
                    $display("%0t: result differs: exp kind %0d data %h pos %h len %h chk %h",
                             $realtime, want.kind, want.data_byte, want.position,
                             want.packet_length, want.expected_check,
                             " / got kind %0d data %h pos %h len %h chk %h",
                             got.kind, got.data_byte, got.position,
                             got.packet_length, got.expected_check);
            end
        end
    endtask

    // Watch both channels and the register port at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sync_marker  = lcpd_pkg::SYNC_RESET;
            phase        = lcpd_pkg::PH_HUNT;
            frame_length = 8'd0;
            byte_index   = 8'd0;
            check_sum    = 8'd0;
            o_fail_count = 0;
            results_due.delete();
        end else begin
            // outputs first: a byte taken now cannot leave in the same cycle
            if (i_m_tvalid && i_m_tready)
                check_result(lcpd_pkg::t_result'({i_m_tuser, i_m_tdata}));
            if (i_cfg_wr_en) sync_marker = i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready) deframe_byte(i_s_tdata);
        end
        o_pending = results_due.size();
        o_hunting = (phase == lcpd_pkg::PH_HUNT);
    end

endmodule

// ===== tb/length_checksum_packet_deframer_top_tb.sv =====
// Testbench top for the packet deframer: byte stimulus, sync register writes and verdict.
`timescale 1ns / 100ps
module length_checksum_packet_deframer_top_tb;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;     // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;              // data_byte, position, packet_length, expected_check
    logic [1:0]  m_axis_tuser;              // [1:0] kind

    int          fail_count;
    int          pending_count;
    logic        hunting;

    logic [7:0]  sync_now     = lcpd_pkg::SYNC_RESET; // marker the block currently hunts for
    bit          tx_steady    = 1'b0;       // sender never idles
    bit          rx_steady    = 1'b0;       // receiver never stalls
    int          packet_bytes = 0;

    length_checksum_packet_deframer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    length_checksum_packet_deframer_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count),
        .o_hunting     (hunting)
    );

    // 50 MHz clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side: random stall before each item, none in steady phases
    initial begin : result_sink
        int   stall;
        logic took;
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do begin
                @(negedge i_clk);
                took = m_axis_tvalid;
                @(posedge i_clk);
            end while (!took);
        end
    end

    // Offer one byte and wait until it is taken; called and returns on a rising edge
    task automatic send_byte(input logic [7:0] rx);
        int   gap;
        logic ready;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= rx;
        s_axis_tvalid <= 1'b1;
        do begin
            @(negedge i_clk);
            ready = s_axis_tready;
            @(posedge i_clk);
        end while (!ready);
    endtask

    // Whole packet with random payload; a bad one gets a corrupted check byte
    task automatic send_frame(input logic [7:0] len, input bit good);
        logic [7:0] sum;
        logic [7:0] payload;
        logic [7:0] chk;
        send_byte(sync_now);
        send_byte(len);
        sum = len;
        for (int i = 0; i < len; i++) begin
            payload = ($urandom_range(0, 7) == 0) ? sync_now : 8'($urandom_range(0, 255));
            sum = sum + payload + 8'(i);
            send_byte(payload);
        end
        chk = ~sum;
        if (!good) chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(chk);
        packet_bytes += len + 3;
    endtask

    // Stop sending, wait for every owed result, then let the pipeline empty
    task automatic drain();
        int left;
        s_axis_tvalid <= 1'b0;
        do begin
            @(negedge i_clk);
            left = pending_count;
            @(posedge i_clk);
        end while (left != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Feed zero bytes until the block is back to hunting
    task automatic finish_packet();
        logic idle;
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        idle = hunting;
        while (!idle) begin
            @(posedge i_clk);
            send_byte(8'h00);
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
            idle = hunting;
        end
        @(posedge i_clk);
    endtask

    // Sync register write, only with no packet in flight
    task automatic write_sync(input logic [7:0] marker);
        finish_packet();
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= marker;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sync_now = marker;
    endtask

    initial begin : stimulus
        int  pick;
        bit  held;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bytes dropped while hunting
        send_byte(8'h00);
        send_byte(8'hff);
        // zero length, good then bad check
        send_byte(lcpd_pkg::SYNC_RESET); send_byte(8'h00); send_byte(8'hff);
        send_byte(lcpd_pkg::SYNC_RESET); send_byte(8'h00); send_byte(8'h00);
        // three bytes, sync value inside the payload, good check
        send_byte(lcpd_pkg::SYNC_RESET); send_byte(8'h03);
        send_byte(8'hff); send_byte(lcpd_pkg::SYNC_RESET); send_byte(8'h00); send_byte(8'hb8);
        // one byte, bad check
        send_byte(lcpd_pkg::SYNC_RESET); send_byte(8'h01); send_byte(8'hff); send_byte(8'h00);

        // random phases, each with its own marker and idling mix
        for (int ph = 0; ph < 4; ph++) begin
            tx_steady = (ph == 1) || (ph == 3);
            rx_steady = (ph >= 2);
            case (ph)
                0:       write_sync(8'h00);
                1:       write_sync(8'hff);
                default: write_sync(8'($urandom_range(0, 255)));
            endcase
            packet_bytes = 0;
            held = 1'b0;
            while (packet_bytes < 140) begin
                pick = $urandom_range(0, 9);
                if (pick <= 6) begin
                    send_frame(($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 12)),
                               $urandom_range(0, 3) != 0);
                end else if (pick == 7) begin
                    // line noise
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                end else if (pick == 8) begin
                    // truncated packet; following bytes get swallowed into it
                    send_byte(sync_now);
                    send_byte(8'($urandom_range(1, 12)));
                    repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
                    packet_bytes += 2;
                end else begin
                    // marker taken as the length byte
                    send_byte(sync_now);
                    send_byte(sync_now);
                    packet_bytes += 2;
                end
                if (ph == 0 && !held && packet_bytes > 100) begin
                    drain();
                    held = 1'b1;
                end
            end
            // longest packet, payload index up to its top
            if (ph == 3) begin
                finish_packet();
                send_frame(8'hff, 1'b1);
            end
        end

        drain();
        if (fail_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
